@@ hw/rtl/cdd_pkg.sv @@
package cdd_pkg;

  // Ring geometry; the depth is always a power of two so pointers wrap for free
  localparam int IdxW  = 4;
  localparam int Depth = 1 << IdxW;
  localparam int CntW  = IdxW + 1;
  localparam int KeyW  = 64;

  // Method codes
  localparam logic [2:0] FUNC_DEVICE_MODE = 3'd0;
  localparam logic [2:0] FUNC_SOUND       = 3'd1;
  localparam logic [2:0] FUNC_LIGHT       = 3'd2;
  localparam logic [2:0] FUNC_GET_STATE   = 3'd3;

  // Failure codes
  localparam logic [1:0] FAIL_NONE        = 2'd0;
  localparam logic [1:0] FAIL_INVALID     = 2'd1;
  localparam logic [1:0] FAIL_UNSUP_PARAM = 2'd2;
  localparam logic [1:0] FAIL_UNSUP_CMD   = 2'd3;

  // Action codes
  localparam logic [2:0] ACT_NONE         = 3'd0;
  localparam logic [2:0] ACT_SET_MODE     = 3'd1;
  localparam logic [2:0] ACT_BUZZER_STOP  = 3'd2;
  localparam logic [2:0] ACT_BUZZER_START = 3'd3;
  localparam logic [2:0] ACT_LED_STOP     = 3'd4;
  localparam logic [2:0] ACT_LED_START    = 3'd5;
  localparam logic [2:0] ACT_REPORT       = 3'd6;
  localparam logic [2:0] ACT_REPORT_LOC   = 3'd7;

  localparam logic [2:0] MODE_MAX         = 3'd4;
  localparam logic [15:0] DEF_DURATION_RST = 16'd30;

  typedef struct packed {
    logic [2:0]         func;
    logic [63:0]        command_key;
    logic               mode_present;
    logic [2:0]         mode_code;
    logic               duration_present;
    logic signed [31:0] dur_sec;
    logic               sleep_now;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  fail_code;
    logic        duplicate;
    logic [2:0]  action;
    logic [2:0]  mode_out;
    logic [30:0] duration_out;
  } res_t;

  // One ring entry: key and its recorded outcome
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            ack;
    logic [1:0]      code;
  } ent_t;

endpackage

@@ hw/rtl/command_dedup_dispatcher.sv @@
// Command dispatcher with duplicate suppression.
//
// Command channel: present a command on cmd_i with start high while busy is
// low; that beat is taken and busy stays high until the result is shown.
// Result channel: res_o is valid for exactly one cycle while res_valid_o is
// high. The receiver cannot stall, so there is no backpressure.
// Config channel: cfg_data_i is written into the default duration register on
// a beat with cfg_valid_i and cfg_ready_o high (ready is always high).
//
// Each command walks the ring of recent keys, one synchronous memory read per
// cycle, oldest first. A new key visits all filled entries, and its result
// shows as it is written into the ring. A hit shows its result once the
// matching entry has been read and compared, ending the walk. busy is low in
// the result cycle, so the next beat can be taken at its end. A new command
// is not taken during a walk, whose pace is set by the single memory read port.
//
// Reset empties the ring (fill count and oldest pointer to zero) and loads the
// default duration with 30 s. Memory contents are not cleared; only reads of
// filled entries are ever compared.
module command_dedup_dispatcher (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  cdd_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  output cdd_pkg::res_t res_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [15:0]   cfg_data_i
);
  import cdd_pkg::*;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e            state_q;
  cmd_t              cmd_q;
  logic [CntW-1:0]   scan_cnt_q;
  logic              rd_vld_q;
  ent_t              rd_ent_q;
  logic [IdxW-1:0]   oldest_q;
  logic [CntW-1:0]   count_q;
  logic [15:0]       def_dur_q;
  logic              res_valid_q;
  res_t              res_q;

  ent_t              mem_q [Depth];

  logic              issue;
  logic [IdxW-1:0]   rd_addr;
  logic              hit;
  logic              walk_done;
  logic              full;
  logic [IdxW-1:0]   wr_addr;
  logic              mem_we;
  ent_t              wr_ent;
  res_t              new_res;
  res_t              dup_res;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Walk control
  assign issue     = (state_q == ST_SCAN) && (scan_cnt_q < count_q);
  assign rd_addr   = oldest_q + scan_cnt_q[IdxW-1:0];
  assign hit       = (state_q == ST_SCAN) && rd_vld_q &&
                     (rd_ent_q.key == cmd_q.command_key[KeyW-1:0]);
  assign walk_done = (state_q == ST_SCAN) && !rd_vld_q && !issue;

  // Ring write for a new key
  assign full    = (count_q == CntW'(Depth));
  assign wr_addr = full ? oldest_q : oldest_q + count_q[IdxW-1:0];
  assign mem_we  = walk_done;
  assign wr_ent  = '{key:  cmd_q.command_key[KeyW-1:0],
                     ack:  !new_res.status,
                     code: new_res.fail_code};

  // Cached outcome resend
  always_comb begin
    dup_res           = '0;
    dup_res.status    = !rd_ent_q.ack;
    dup_res.fail_code = rd_ent_q.ack ? FAIL_NONE : rd_ent_q.code;
    dup_res.duplicate = 1'b1;
  end

  // Validation and dispatch of a new command
  always_comb begin
    new_res = '0;
    unique case (cmd_q.func)
      FUNC_DEVICE_MODE: begin
        if (!cmd_q.mode_present) begin
          new_res.status    = 1'b1;
          new_res.fail_code = FAIL_INVALID;
        end else if (cmd_q.mode_code > MODE_MAX) begin
          new_res.status    = 1'b1;
          new_res.fail_code = FAIL_UNSUP_PARAM;
        end else begin
          new_res.action   = ACT_SET_MODE;
          new_res.mode_out = cmd_q.mode_code;
        end
      end
      FUNC_SOUND, FUNC_LIGHT: begin
        if (cmd_q.duration_present && cmd_q.dur_sec[31]) begin
          new_res.status    = 1'b1;
          new_res.fail_code = FAIL_INVALID;
        end else if (cmd_q.duration_present && (cmd_q.dur_sec == 32'sd0)) begin
          new_res.action = (cmd_q.func == FUNC_SOUND) ? ACT_BUZZER_STOP : ACT_LED_STOP;
        end else begin
          new_res.action = (cmd_q.func == FUNC_SOUND) ? ACT_BUZZER_START : ACT_LED_START;
          new_res.duration_out = cmd_q.duration_present ?
                                 cmd_q.dur_sec[30:0] : 31'(def_dur_q);
        end
      end
      FUNC_GET_STATE: begin
        new_res.action = cmd_q.sleep_now ? ACT_REPORT_LOC : ACT_REPORT;
      end
      default: begin
        new_res.status    = 1'b1;
        new_res.fail_code = FAIL_UNSUP_CMD;
      end
    endcase
  end

  // Control state, ring pointers and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      scan_cnt_q  <= '0;
      rd_vld_q    <= 1'b0;
      oldest_q    <= '0;
      count_q     <= '0;
      def_dur_q   <= DEF_DURATION_RST;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= hit || walk_done;
      if (cfg_valid_i && cfg_ready_o) begin
        def_dur_q <= cfg_data_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            cmd_q      <= cmd_i;
            scan_cnt_q <= '0;
            rd_vld_q   <= 1'b0;
            state_q    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_vld_q <= issue && !hit;
          if (issue) begin
            scan_cnt_q <= scan_cnt_q + 1'b1;
          end
          if (hit) begin
            res_q   <= dup_res;
            state_q <= ST_IDLE;
          end else if (walk_done) begin
            res_q   <= new_res;
            state_q <= ST_IDLE;
            if (full) begin
              oldest_q <= oldest_q + 1'b1;
            end else begin
              count_q <= count_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Ring memory: one write port, one registered read port. The write lands at
  // the edge that opens the result cycle, before any read of the next command.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_ent;
    end
    rd_ent_q <= mem_q[rd_addr];
  end

  // Fill count never passes the ring depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("ring fill count above depth");

  // A successful result never carries a failure code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.status |-> res_o.fail_code == FAIL_NONE)
    else $error("acknowledged result with failure code");

  // A result ends the command: busy is already low while it is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("busy still high with result shown");

  // The ring only grows or advances on a new key's result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q) || oldest_q != $past(oldest_q)) |->
      res_valid_o && !res_o.duplicate)
    else $error("ring pointers moved without a new entry");

endmodule

@@ tb/sv/tb_command_dedup_dispatcher.sv @@
module tb_command_dedup_dispatcher;
  timeunit 1ns;
  timeprecision 1ps;

  import cdd_pkg::*;

  // Method codes the package leaves out; all of them are rejected
  localparam logic [2:0] FUNC_OTA     = 3'd4;
  localparam logic [2:0] FUNC_UNKNOWN = 3'd5;
  localparam logic [2:0] FUNC_SPARE6  = 3'd6;
  localparam logic [2:0] FUNC_SPARE7  = 3'd7;

  localparam int QUIET_LIMIT = 2000;
  localparam int POOL_SIZE   = 24;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  cmd_t          cmd = '0;
  logic          res_valid_o;
  res_t          res_o;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready_o;
  logic [15:0]   cfg_data = '0;

  // Commands waiting to be sent, outcomes waiting to be seen
  cmd_t          cmd_queue[$];
  res_t          outcome_fifo[$];
  logic [63:0]   key_pool[POOL_SIZE];
  int            mismatch_count = 0;
  int            quiet_cycles = 0;

  // Shadow of the block: recent-key ring and default duration
  logic [63:0]   seen_key[Depth];
  logic          seen_ack[Depth];
  logic [1:0]    seen_code[Depth];
  logic [IdxW-1:0] seen_oldest = '0;
  logic [CntW-1:0] seen_count = '0;
  logic [15:0]   dflt_duration = DEF_DURATION_RST;

  command_dedup_dispatcher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Outcome of one command; updates the shadow ring on a new key
  function automatic res_t dispatch_outcome(input cmd_t c);
    res_t          r;
    int            hit;
    logic [IdxW-1:0] pos;
    logic          fail;
    logic [1:0]    code;
    r = '0;
    hit = -1;
    fail = 1'b0;
    code = FAIL_NONE;
    for (int i = 0; i < seen_count; i++) begin
      pos = seen_oldest + i[IdxW-1:0];
      if (hit < 0 && seen_key[pos] == c.command_key) hit = int'(pos);
    end
    if (hit >= 0) begin
      r.status = !seen_ack[hit];
      r.fail_code = seen_ack[hit] ? FAIL_NONE : seen_code[hit];
      r.duplicate = 1'b1;
      return r;
    end
    case (c.func)
      FUNC_DEVICE_MODE: begin
        if (!c.mode_present) begin
          fail = 1'b1;
          code = FAIL_INVALID;
        end else if (c.mode_code > MODE_MAX) begin
          fail = 1'b1;
          code = FAIL_UNSUP_PARAM;
        end else begin
          r.action = ACT_SET_MODE;
          r.mode_out = c.mode_code;
        end
      end
      FUNC_SOUND, FUNC_LIGHT: begin
        if (c.duration_present && c.dur_sec[31]) begin
          fail = 1'b1;
          code = FAIL_INVALID;
        end else if (c.duration_present && c.dur_sec == 0) begin
          r.action = (c.func == FUNC_SOUND) ? ACT_BUZZER_STOP : ACT_LED_STOP;
        end else begin
          r.action = (c.func == FUNC_SOUND) ? ACT_BUZZER_START : ACT_LED_START;
          r.duration_out = c.duration_present ? c.dur_sec[30:0]
                                              : {15'd0, dflt_duration};
        end
      end
      FUNC_GET_STATE: begin
        r.action = c.sleep_now ? ACT_REPORT_LOC : ACT_REPORT;
      end
      default: begin
        fail = 1'b1;
        code = FAIL_UNSUP_CMD;
      end
    endcase
    // record the outcome; overwrite the oldest once full
    if (seen_count < Depth) begin
      pos = seen_oldest + seen_count[IdxW-1:0];
      seen_count = seen_count + 1'b1;
    end else begin
      pos = seen_oldest;
      seen_oldest = seen_oldest + 1'b1;
    end
    seen_key[pos] = c.command_key;
    seen_ack[pos] = !fail;
    seen_code[pos] = fail ? code : FAIL_NONE;
    r.status = fail;
    r.fail_code = code;
    return r;
  endfunction

  function automatic cmd_t make_cmd(input logic [2:0] func, input logic [63:0] key,
                                    input logic mp, input logic [2:0] mc,
                                    input logic dp, input logic [31:0] dur,
                                    input logic sleep);
    cmd_t c;
    c.func = func;
    c.command_key = key;
    c.mode_present = mp;
    c.mode_code = mc;
    c.duration_present = dp;
    c.dur_sec = dur;
    c.sleep_now = sleep;
    return c;
  endfunction

  // Command driver: bursts of commands with random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    int   gap_left;
    int   burst_left;
    logic took;
    if (!rst_ni) begin
      start <= 1'b0;
      cmd <= '0;
      gap_left = 0;
      burst_left = 1;
    end else begin
      took = start && !busy;
      if (took) begin
        outcome_fifo.push_back(dispatch_outcome(cmd));
        void'(cmd_queue.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
      // a beat not yet taken stays on the port
      if (!(start && !took)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          start <= 1'b1;
          cmd <= cmd_queue[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [30:0] want,
                             input logic [30:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result monitor: every result beat is checked against the oldest outcome
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (outcome_fifo.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, res_o);
        mismatch_count++;
      end else begin
        want = outcome_fifo.pop_front();
        check_field("status", 31'(want.status), 31'(res_o.status));
        check_field("fail_code", 31'(want.fail_code), 31'(res_o.fail_code));
        check_field("duplicate", 31'(want.duplicate), 31'(res_o.duplicate));
        check_field("action", 31'(want.action), 31'(res_o.action));
        check_field("mode_out", 31'(want.mode_out), 31'(res_o.mode_out));
        check_field("duration_out", want.duration_out, res_o.duration_out);
      end
    end
  end

  // Watchdog on cycles where no beat moves on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o || (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_command_dedup_dispatcher: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold off until every queued command is answered and the block is idle
  task automatic drain();
    do @(posedge clk_i);
    while (cmd_queue.size() != 0 || start || outcome_fifo.size() != 0 || busy);
  endtask

  task automatic write_default(input logic [15:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    cfg_data <= 16'($urandom());
    dflt_duration = value;
  endtask

  task automatic queue_random(input int count);
    cmd_t c;
    int   sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 9);
      if (sel < 2) c.func = FUNC_DEVICE_MODE;
      else if (sel < 4) c.func = FUNC_SOUND;
      else if (sel < 6) c.func = FUNC_LIGHT;
      else if (sel < 8) c.func = FUNC_GET_STATE;
      else if (sel == 8) c.func = FUNC_OTA;
      else c.func = 3'($urandom_range(FUNC_UNKNOWN, FUNC_SPARE7));
      // mostly reuse a small key pool so hits and evictions both occur
      if ($urandom_range(0, 9) < 7) c.command_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else c.command_key = {$urandom(), $urandom()};
      c.mode_present = ($urandom_range(0, 6) != 0);
      c.mode_code = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(0, MODE_MAX));
      c.duration_present = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0: c.dur_sec = '0;
        1: c.dur_sec = {1'b1, 31'($urandom())};
        2: c.dur_sec = $urandom_range(1, 1000);
        3: c.dur_sec = 32'h7FFF_FFFF;
        default: c.dur_sec = $urandom();
      endcase
      c.sleep_now = 1'($urandom_range(0, 1));
      cmd_queue.push_back(c);
    end
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom(), $urandom()};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every method, parameter checks, duplicates, eviction
    cmd_queue.push_back(make_cmd(FUNC_DEVICE_MODE, '0, 1'b0, MODE_MAX, 1'b1, '1, 1'b0));
    cmd_queue.push_back(make_cmd(FUNC_DEVICE_MODE, '1, 1'b1, '0, 1'b0, '0, 1'b1));
    cmd_queue.push_back(make_cmd(FUNC_DEVICE_MODE, 64'hC0DE_0003, 1'b1, MODE_MAX,
                                 1'b0, '0, 1'b0));
    cmd_queue.push_back(make_cmd(FUNC_DEVICE_MODE, 64'hC0DE_0004, 1'b1,
                                 MODE_MAX + 3'd1, 1'b0, '0, 1'b0));
    cmd_queue.push_back(make_cmd(FUNC_DEVICE_MODE, 64'hC0DE_0005, 1'b1, '1, 1'b0, '0, 1'b0));
    // repeated keys resend the cached outcome, whatever the new fields say
    cmd_queue.push_back(make_cmd(FUNC_GET_STATE, '0, 1'b1, '0, 1'b0, '0, 1'b0));
    cmd_queue.push_back(make_cmd(FUNC_OTA, '1, 1'b0, '0, 1'b0, '0, 1'b0));
    // sound: default, zero, most negative, largest
    cmd_queue.push_back(make_cmd(FUNC_SOUND, 64'hC0DE_0006, 1'b0, '0, 1'b0,
                                 32'h8000_0000, 1'b0));
    cmd_queue.push_back(make_cmd(FUNC_SOUND, 64'hC0DE_0007, 1'b0, '0, 1'b1, '0, 1'b0));
    cmd_queue.push_back(make_cmd(FUNC_SOUND, 64'hC0DE_0008, 1'b0, '0, 1'b1,
                                 32'h8000_0000, 1'b0));
    cmd_queue.push_back(make_cmd(FUNC_SOUND, 64'hC0DE_0009, 1'b0, '0, 1'b1,
                                 32'h7FFF_FFFF, 1'b0));
    // light: default, zero, minus one, one
    cmd_queue.push_back(make_cmd(FUNC_LIGHT, 64'hC0DE_000A, 1'b1, '1, 1'b0, '1, 1'b1));
    cmd_queue.push_back(make_cmd(FUNC_LIGHT, 64'hC0DE_000B, 1'b0, '0, 1'b1, '0, 1'b0));
    cmd_queue.push_back(make_cmd(FUNC_LIGHT, 64'hC0DE_000C, 1'b0, '0, 1'b1, '1, 1'b0));
    cmd_queue.push_back(make_cmd(FUNC_LIGHT, 64'hC0DE_000D, 1'b0, '0, 1'b1, 32'd1, 1'b0));
    // state report, awake and asleep
    cmd_queue.push_back(make_cmd(FUNC_GET_STATE, 64'hC0DE_000E, 1'b0, '0, 1'b0, '0, 1'b0));
    cmd_queue.push_back(make_cmd(FUNC_GET_STATE, 64'hC0DE_000F, 1'b0, '0, 1'b0, '0, 1'b1));
    // unsupported commands
    cmd_queue.push_back(make_cmd(FUNC_OTA, 64'hC0DE_0010, 1'b1, '0, 1'b1, 32'd5, 1'b0));
    cmd_queue.push_back(make_cmd(FUNC_UNKNOWN, 64'hC0DE_0011, 1'b0, '0, 1'b0, '0, 1'b0));
    cmd_queue.push_back(make_cmd(FUNC_SPARE6, 64'hC0DE_0012, 1'b0, '0, 1'b0, '0, 1'b0));
    cmd_queue.push_back(make_cmd(FUNC_SPARE7, 64'hC0DE_0013, 1'b0, '0, 1'b0, '0, 1'b0));
    // cached failure still in the ring; key zero has been evicted by now
    cmd_queue.push_back(make_cmd(FUNC_SOUND, 64'hC0DE_0010, 1'b0, '0, 1'b0, '0, 1'b0));
    cmd_queue.push_back(make_cmd(FUNC_DEVICE_MODE, '0, 1'b1, 3'd2, 1'b0, '0, 1'b0));

    // Random phases across default-duration settings, extremes included
    write_default(16'h0000);
    queue_random(150);
    write_default(16'hFFFF);
    queue_random(150);
    write_default(16'($urandom_range(0, 65535)));
    queue_random(250);
    write_default(16'h0001);
    queue_random(250);

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && outcome_fifo.size() == 0) begin
      $display("tb_command_dedup_dispatcher: PASS");
    end else begin
      $display("tb_command_dedup_dispatcher: FAIL");
    end
    $finish;
  end

endmodule
